// ----- design/u8dec_pkg.sv -----
`default_nettype none

package u8dec_pkg;

  localparam int unsigned GroupBytes = 4;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned CodeWidth  = 21;

  typedef enum logic [0:0] {
    REG_DROP_BOM = 1'b0
  } reg_index_t;

  localparam logic [7:0] BomByte0 = 8'hEF;
  localparam logic [7:0] BomByte1 = 8'hBB;
  localparam logic [7:0] BomByte2 = 8'hBF;

  localparam logic [7:0] MaskOne   = 8'h7F;
  localparam logic [7:0] MaskTwo   = 8'h1F;
  localparam logic [7:0] MaskThree = 8'h0F;
  localparam logic [7:0] MaskFour  = 8'h07;
  localparam logic [7:0] MaskCont  = 8'h3F;

  localparam logic [CountWidth-1:0] CountOne   = 3'd1;
  localparam logic [CountWidth-1:0] CountTwo   = 3'd2;
  localparam logic [CountWidth-1:0] CountThree = 3'd3;
  localparam logic [CountWidth-1:0] CountFour  = 3'd4;

  // one pending byte group, byte 0 is the lead
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;
    logic [CountWidth-1:0]      count;
  } group_t;

  // all results caused by one input byte
  typedef struct packed {
    group_t first;
    group_t second;
    logic   pair;
  } job_t;

  function automatic logic is_bom(input group_t g);
    return (g.count == CountThree) && (g.bytes[0] == BomByte0) &&
           (g.bytes[1] == BomByte1) && (g.bytes[2] == BomByte2);
  endfunction

  function automatic logic [CodeWidth-1:0] decode_group(input group_t g);
    logic [CodeWidth-1:0] v;
    v = '0;
    unique case (g.count)
      CountOne:   v = {14'd0, g.bytes[0][6:0] & MaskOne[6:0]};
      CountTwo:   v = {10'd0, g.bytes[0][4:0] & MaskTwo[4:0],
                       g.bytes[1][5:0] & MaskCont[5:0]};
      CountThree: v = {5'd0, g.bytes[0][3:0] & MaskThree[3:0],
                       g.bytes[1][5:0] & MaskCont[5:0],
                       g.bytes[2][5:0] & MaskCont[5:0]};
      CountFour:  v = {g.bytes[0][2:0] & MaskFour[2:0],
                       g.bytes[1][5:0] & MaskCont[5:0],
                       g.bytes[2][5:0] & MaskCont[5:0],
                       g.bytes[3][5:0] & MaskCont[5:0]};
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/u8dec_front.sv -----
`default_nettype none

module u8dec_front
  import u8dec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  input  wire logic       drop_bom,
  output logic            push,
  output job_t            job
);

  logic [GroupBytes-1:0][7:0] pending;
  logic [GroupBytes-1:0][7:0] pending_next;
  logic [CountWidth-1:0]      count;
  logic [CountWidth-1:0]      count_next;
  logic                       aborted;
  logic                       aborted_next;

  always_comb begin
    logic                       starts;
    logic                       emit0;
    logic                       emit1;
    group_t                     g0;
    group_t                     g1;
    logic [GroupBytes-1:0][7:0] bytes1;
    logic [CountWidth-1:0]      cnt1;

    g0.bytes     = pending;
    g0.count     = count;
    starts       = (data_byte[7] == 1'b0) || (data_byte[7:6] == 2'b11);
    emit0        = 1'b0;
    emit1        = 1'b0;
    bytes1       = pending;
    cnt1         = count;
    pending_next = pending;
    count_next   = count;
    aborted_next = aborted;

    if (aborted) begin
      if (end_of_string) aborted_next = 1'b0;
    end else begin
      if (starts && (count != '0)) begin
        emit0 = !(drop_bom && is_bom(g0));
        cnt1  = '0;
      end
      if (cnt1 >= CountFour) begin
        // overlong group, discard up to the end mark
        count_next = '0;
        if (!end_of_string) aborted_next = 1'b1;
      end else begin
        bytes1[cnt1[1:0]] = data_byte;
        pending_next      = bytes1;
        if (end_of_string) begin
          count_next = '0;
        end else begin
          count_next = cnt1 + CountOne;
        end
      end
    end

    g1.bytes = bytes1;
    g1.count = cnt1 + CountOne;
    if (!aborted && (cnt1 < CountFour) && end_of_string) begin
      emit1 = !(drop_bom && is_bom(g1));
    end

    // first slot always holds the earliest emitted group
    job.first  = emit0 ? g0 : g1;
    job.second = g1;
    job.pair   = emit0 && emit1;
    push       = accept && (emit0 || emit1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      aborted <= 1'b0;
    end else if (accept) begin
      count   <= count_next;
      aborted <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pending <= pending_next;
  end

endmodule

`default_nettype wire

// ----- design/u8dec_queue.sv -----
`default_nettype none

module u8dec_queue
  import u8dec_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      empty,
  output logic      full
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  job_t            entries [DEPTH];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign empty    = (fill == '0);
  assign full     = (fill == DepthC);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// ----- design/u8dec_back.sv -----
`default_nettype none

module u8dec_back
  import u8dec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire job_t                 head_job,
  output logic                      pop,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [CodeWidth-1:0]      codepoint,
  output logic                      last_of_run
);

  logic   second_sel;
  logic   load;
  logic   is_last;
  group_t cur;

  assign load    = head_valid && (!out_valid || out_ready);
  assign cur     = second_sel ? head_job.second : head_job.first;
  assign is_last = !head_job.pair || second_sel;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      second_sel <= 1'b0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        second_sel <= !is_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codepoint   <= decode_group(cur);
      last_of_run <= is_last;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8_byte_stream_decoder_core.sv -----
// channel   | dir | handshake               | payload
// s_*       | in  | s_tvalid / s_tready     | s_tdata = data_byte, s_tlast = end_of_string
// m_*       | out | m_tvalid / m_tready     | m_tdata = codepoint, m_tlast = last_of_run
// apb       | in  | psel & penable & pwrite | reg 0 at 0x0: drop_byte_order_mark
//
// one byte per cycle in unless the queue is full; the front tracks the pending group
// a byte that flushes two groups yields two codepoints from the back end,
// the job queue (QUEUE_DEPTH entries) soaks that up between the two sides
// a finished group goes through the job queue and then the output register
// rst is synchronous: empties queue and group, drop_byte_order_mark back to 1
// s_tready drops only while the job queue is full
`default_nettype none

module utf8_byte_stream_decoder_core
  import u8dec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] codepoint, [23:21] zero
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                 drop_bom;
  logic                 in_accept;
  logic                 push;
  job_t                 push_job;
  job_t                 head_job;
  logic                 q_empty;
  logic                 q_full;
  logic                 pop;
  logic [CodeWidth-1:0] codepoint;

  // config register, addressed by word index
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_bom <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index_t'(paddr[2]) == REG_DROP_BOM)) begin
      drop_bom <= pwdata[0];
    end
  end

  assign prdata = (reg_index_t'(paddr[2]) == REG_DROP_BOM) ? {31'd0, drop_bom} : '0;

  // front end: takes a byte whenever the queue has room
  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;

  u8dec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .data_byte     (s_tdata),
    .end_of_string (s_tlast),
    .drop_bom      (drop_bom),
    .push          (push),
    .job           (push_job)
  );

  // job queue between the two sides
  u8dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: decodes one group per cycle into the output register when not stalled
  u8dec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .codepoint   (codepoint),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {3'd0, codepoint};

endmodule

`default_nettype wire

// ----- design/u8dec_checker.sv -----
`default_nettype none

module u8dec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);

  // set after a transaction that is not the last of its byte
  logic open_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_pair <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      open_pair <= !m_tlast;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'd0)
    else $error("codepoint padding not zero");

  a_pair_closes: assert property (@(posedge clk) disable iff (rst)
    open_pair && m_tvalid |-> m_tlast)
    else $error("second result of a byte lacks tlast");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind utf8_byte_stream_decoder_core u8dec_checker u_checker (.*);

`default_nettype wire
